### design/cars_pkg.sv
`default_nettype none

package cars_pkg;

  localparam int ROW_BITS      = 64;
  localparam int MAX_ROW_CELLS = 64;
  localparam int MIN_ROW_CELLS = 3;
  localparam int SURVIVE_MIN   = 4;
  localparam int BIRTH_MIN     = 5;
  localparam int WIDTH_BITS    = 7;
  localparam int NCOUNT_BITS   = 4;

  // configuration register indexes
  localparam logic CFG_ROW_WIDTH     = 1'b0;
  localparam logic CFG_CLEAR_BORDERS = 1'b1;

  // rows of the current grid held
  typedef enum logic [1:0] {
    RS_EMPTY = 2'd0,
    RS_ONE   = 2'd1,
    RS_TWO   = 2'd2
  } rows_state_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] cells;
    logic                done;
  } result_t;

endpackage

`default_nettype wire

### design/cave_automaton_row_smoother.sv
`default_nettype none

// One smoothing pass of a binary cave automaton (birth at 5+, survival at 4+
// wall neighbours), one grid row per word, bit i = cell i, 1 = wall.
// Input channel in_*: a row plus final_row marking the bottom row of a grid.
// Output channel out_*: smoothed rows in raster order, grid_done on the last.
// Config channel cfg_*: index 0 row_width (7 bits), index 1 clear_borders;
// always ready, write only while the block is idle.
// A row's word lands in an input register, then one combinational pass
// (per-cell 8-input neighbour count and compare) drops up to two result
// words into a two-entry output buffer, whose head word is shown on out_*.
// Throughput: one row per cycle while the output buffer has room, set by the
// single pass from input register to output buffer. A final row that follows
// another row makes two result words and waits until the buffer is empty.
// A first row that is not final makes no word; it comes out with the next row.
// Reset (synchronous, rst_n low) clears the input valid flag, row state and
// buffer count, sets row_width to 64 and clear_borders to 0. When out_ready
// stays low the buffer fills and in_ready drops; words are held, none lost.
module cave_automaton_row_smoother (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cars_pkg::ROW_BITS-1:0]  in_row_cells,
  input  wire logic                           in_final_row,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [cars_pkg::ROW_BITS-1:0]  out_smoothed_cells,
  output logic                                out_grid_done,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_index,
  input  wire logic [cars_pkg::WIDTH_BITS-1:0] cfg_data
);

  localparam int RB = cars_pkg::ROW_BITS;
  localparam int WB = cars_pkg::WIDTH_BITS;
  localparam int NB = cars_pkg::NCOUNT_BITS;

  logic [WB-1:0]          row_width_r;
  logic                   clear_borders_r;
  cars_pkg::rows_state_t  rs_r, rs_nxt;
  logic [RB-1:0]          above_r, above_nxt;
  logic [RB-1:0]          centre_r, centre_nxt;
  logic                   inr_valid_r;
  logic [RB-1:0]          inr_row_r;
  logic                   inr_last_r;
  cars_pkg::result_t      slot0_r, slot0_nxt;
  cars_pkg::result_t      slot1_r, slot1_nxt;
  logic [1:0]             cnt_r, cnt_nxt;

  logic [WB-1:0]          weff;
  logic [RB-1:0]          mask;
  logic [RB-1:0]          row_m, above_m, centre_m;
  logic [RB-1:0]          interior;
  logic [RB-1:0]          smoothed;
  logic [RB-1:0]          border;
  logic [1:0]             n_res;
  logic                   adv;
  logic                   pop;
  cars_pkg::result_t      first_res, final_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= WB'(cars_pkg::MAX_ROW_CELLS);
      clear_borders_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cars_pkg::CFG_ROW_WIDTH:     row_width_r     <= cfg_data;
        cars_pkg::CFG_CLEAR_BORDERS: clear_borders_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective width and row mask
  always_comb begin
    if (row_width_r < WB'(cars_pkg::MIN_ROW_CELLS)) begin
      weff = WB'(cars_pkg::MIN_ROW_CELLS);
    end else if (row_width_r > WB'(cars_pkg::MAX_ROW_CELLS)) begin
      weff = WB'(cars_pkg::MAX_ROW_CELLS);
    end else begin
      weff = row_width_r;
    end
    for (int i = 0; i < RB; i++) begin
      mask[i] = (WB'(i) < weff);
    end
  end

  assign row_m    = inr_row_r & mask;
  assign above_m  = above_r & mask;
  assign centre_m = centre_r & mask;
  assign border   = clear_borders_r ? '0 : mask;
  // cells 1 .. w-2
  assign interior = (mask >> 1) & ~RB'(1);

  always_comb begin
    logic [NB-1:0] nc;
    logic          wall;
    smoothed = '0;
    for (int i = 1; i < RB - 1; i++) begin
      nc = NB'(above_m[i-1]) + NB'(above_m[i]) + NB'(above_m[i+1])
         + NB'(centre_m[i-1]) + NB'(centre_m[i+1])
         + NB'(row_m[i-1]) + NB'(row_m[i]) + NB'(row_m[i+1]);
      wall = centre_m[i] ? (nc >= NB'(cars_pkg::SURVIVE_MIN))
                         : (nc >= NB'(cars_pkg::BIRTH_MIN));
      smoothed[i] = wall & interior[i];
    end
    if (!clear_borders_r) begin
      // left edge and right edge (bit w-1)
      smoothed = smoothed | RB'(1) | (mask ^ (mask >> 1));
    end
  end

  assign n_res = 2'((rs_r != cars_pkg::RS_EMPTY)) + 2'(inr_last_r);
  assign adv   = inr_valid_r && ((3'(cnt_r) + 3'(n_res)) <= 3'd2);
  assign pop   = out_valid && out_ready;

  assign in_ready = !inr_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_valid_r <= 1'b0;
    end else if (in_ready) begin
      inr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inr_row_r  <= in_row_cells;
      inr_last_r <= in_final_row;
    end
  end

  // held rows state; held rows keep the mask they were stored with
  always_comb begin
    rs_nxt     = rs_r;
    above_nxt  = above_r;
    centre_nxt = centre_r;
    if (adv) begin
      case (rs_r)
        cars_pkg::RS_EMPTY: begin
          centre_nxt = row_m;
          rs_nxt     = cars_pkg::RS_ONE;
        end
        cars_pkg::RS_ONE, cars_pkg::RS_TWO: begin
          above_nxt  = centre_r;
          centre_nxt = row_m;
          rs_nxt     = cars_pkg::RS_TWO;
        end
        default: rs_nxt = cars_pkg::RS_EMPTY;
      endcase
      if (inr_last_r) begin
        rs_nxt = cars_pkg::RS_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= cars_pkg::RS_EMPTY;
    end else begin
      rs_r <= rs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    above_r  <= above_nxt;
    centre_r <= centre_nxt;
  end

  // output buffer: slot0 is shown on out_*, slot1 waits behind it
  always_comb begin
    logic [1:0] rem;
    final_res.cells = border;
    final_res.done  = 1'b1;
    first_res.done  = 1'b0;
    first_res.cells = (rs_r == cars_pkg::RS_TWO) ? smoothed : border;
    if (rs_r == cars_pkg::RS_EMPTY) begin
      first_res = final_res;
    end

    rem       = cnt_r - 2'(pop);
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop && cnt_r == 2'd2) begin
      slot0_nxt = slot1_r;
    end
    cnt_nxt = rem;
    if (adv && n_res != 2'd0) begin
      cnt_nxt = rem + n_res;
      if (rem == 2'd0) begin
        slot0_nxt = first_res;
        slot1_nxt = final_res;
      end else begin
        slot1_nxt = first_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid          = (cnt_r != 2'd0);
  assign out_smoothed_cells = slot0_r.cells;
  assign out_grid_done      = slot0_r.done;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("output buffer count out of range");

  a_adv_room: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> ((3'(cnt_r) + 3'(n_res)) <= 3'd2))
    else $error("row advanced without buffer room");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && inr_last_r) |=> (rs_r == cars_pkg::RS_EMPTY))
    else $error("held rows not released after final row");

  a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (inr_valid_r && rs_r == cars_pkg::RS_EMPTY) |-> (n_res == 2'(inr_last_r)))
    else $error("first row of grid produced a word on its own");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_smoothed_cells) && $stable(out_grid_done)))
    else $error("output word changed while waiting");

endmodule

`default_nettype wire
